[src/iwd_pkg.sv]
// Shared types, widths and constants of the insulation PWM status decoder.
`timescale 1ns / 1ps

package iwd_pkg;

    // Field widths
    localparam int FREQ_W     = 16;
    localparam int DUTY_W     = 14;
    localparam int HW_W       = 12;
    localparam int RES_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Divider: one quotient bit per stage; quotient always fits RES_W bits
    localparam int DIV_STAGES = RES_W;
    localparam int DIV_N_W    = 24;
    localparam logic [DIV_N_W-1:0] DIV_DIVIDEND = 24'd10800000;
    localparam logic [DUTY_W-1:0]  DIV_INIT     = DUTY_W'(DIV_DIVIDEND >> DIV_STAGES);

    // Resistance constants, kOhm
    localparam logic [RES_W-1:0] RES_MAX_KOHM = 17'd106800;
    localparam logic [RES_W-1:0] RES_OFFSET   = 17'd1200;

    // Duty thresholds, 0.01 % units
    localparam logic [DUTY_W-1:0] DUTY_NORM_LO = 14'd400;
    localparam logic [DUTY_W-1:0] DUTY_NORM_HI = 14'd9600;
    localparam logic [DUTY_W-1:0] DUTY_SSG_LO  = 14'd400;
    localparam logic [DUTY_W-1:0] DUTY_SSG_HI  = 14'd1100;
    localparam logic [DUTY_W-1:0] DUTY_SSB_LO  = 14'd8900;
    localparam logic [DUTY_W-1:0] DUTY_SSB_HI  = 14'd9600;
    localparam logic [DUTY_W-1:0] DUTY_ERR_LO  = 14'd4650;
    localparam logic [DUTY_W-1:0] DUTY_ERR_HI  = 14'd5350;
    localparam logic [DUTY_W-1:0] DUTY_RES_BASE = 14'd500;
    // at or below this duty the quotient reaches saturation anyway
    localparam logic [DUTY_W-1:0] DUTY_DIV_MIN = 14'd600;
    localparam logic [DUTY_W-1:0] DUTY_RES_TOP = 14'd9500;

    // Reset values of the configuration registers
    localparam logic [FREQ_W-1:0] RST_NORMAL_CENTRE = 16'd1000;
    localparam logic [FREQ_W-1:0] RST_UV_CENTRE     = 16'd2000;
    localparam logic [FREQ_W-1:0] RST_SS_CENTRE     = 16'd3000;
    localparam logic [FREQ_W-1:0] RST_DEVERR_CENTRE = 16'd4000;
    localparam logic [FREQ_W-1:0] RST_GNDERR_CENTRE = 16'd5000;
    localparam logic [HW_W-1:0]   RST_HALF_WIDTH    = 12'd200;
    localparam logic [FREQ_W-1:0] RST_SHORT_CLAMP   = 16'd10;

    typedef enum logic [2:0] {
        MODE_NORMAL, MODE_UNDERVOLT, MODE_SPEEDSTART, MODE_DEV_ERR,
        MODE_GND_ERR, MODE_SHORT, MODE_UNDEF
    } mode_t;

    typedef enum logic [3:0] {
        ST_RES, ST_RES_UNK, ST_ESTIM, ST_ESTIM_UNK, ST_UV, ST_UV_UNK,
        ST_DEVERR, ST_DEVERR_UNK, ST_GNDERR, ST_GNDERR_UNK, ST_SHORT, ST_INVALID
    } meas_state_t;

    typedef enum logic [1:0] {
        RES_ZERO, RES_MAX, RES_DIV
    } res_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL, CFG_UNDERVOLT, CFG_SPEEDSTART, CFG_DEV_ERR,
        CFG_GND_ERR, CFG_HALF_WIDTH, CFG_SHORT_CLAMP
    } cfg_idx_t;

    // Classified word handed from front to back
    typedef struct packed {
        mode_t             mode;
        meas_state_t       meas_state;
        logic              valid_res;
        logic              undervoltage;
        logic              status_pin;
        res_kind_t         kind;
        logic [DUTY_W-1:0] divisor;
    } item_t;

    // Finished result word
    typedef struct packed {
        mode_t            mode;
        meas_state_t      meas_state;
        logic             valid_res;
        logic             undervoltage;
        logic [RES_W-1:0] insul_kohm;
        logic             status_pin_out;
    } result_t;

endpackage

[src/iwd_front.sv]
// Front: configuration registers, band sorting and duty window checks.
`timescale 1ns / 1ps

module iwd_front
    import iwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FREQ_W-1:0]     in_freq,
    input  logic [DUTY_W-1:0]     in_duty,
    input  logic                  in_pin,
    output logic                  out_valid,
    input  logic                  out_ready,
    output item_t                 out_item
);

    logic [FREQ_W-1:0] normal_c_reg, uv_c_reg, ss_c_reg, deverr_c_reg, gnderr_c_reg;
    logic [FREQ_W-1:0] short_clamp_reg;
    logic [HW_W-1:0]   half_width_reg;
    logic              valid_reg, valid_next;
    item_t             item_reg, item_next;
    logic              accept;

    // band is [centre - hw, centre + hw), compared without signs
    function automatic logic in_band(input logic [FREQ_W-1:0] f,
                                     input logic [FREQ_W-1:0] c,
                                     input logic [HW_W-1:0]   hw);
        logic [FREQ_W:0] f_ext, c_ext, hw_ext;
        f_ext  = {1'b0, f};
        c_ext  = {1'b0, c};
        hw_ext = (FREQ_W+1)'(hw);
        return ((f_ext + hw_ext) >= c_ext) && (f_ext < (c_ext + hw_ext));
    endfunction

    function automatic logic duty_open(input logic [DUTY_W-1:0] d,
                                       input logic [DUTY_W-1:0] lo,
                                       input logic [DUTY_W-1:0] hi);
        return (d > lo) && (d < hi);
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Classification
    always_comb begin
        item_next              = item_reg;
        item_next.status_pin   = in_pin;
        item_next.divisor      = in_duty - DUTY_RES_BASE;
        item_next.valid_res    = 1'b0;
        item_next.undervoltage = 1'b0;
        item_next.kind         = RES_ZERO;
        item_next.meas_state   = ST_INVALID;

        priority if (in_band(in_freq, normal_c_reg, half_width_reg)) begin
            item_next.mode = MODE_NORMAL;
        end else if (in_band(in_freq, uv_c_reg, half_width_reg)) begin
            item_next.mode = MODE_UNDERVOLT;
        end else if (in_band(in_freq, ss_c_reg, half_width_reg)) begin
            item_next.mode = MODE_SPEEDSTART;
        end else if (in_band(in_freq, deverr_c_reg, half_width_reg)) begin
            item_next.mode = MODE_DEV_ERR;
        end else if (in_band(in_freq, gnderr_c_reg, half_width_reg)) begin
            item_next.mode = MODE_GND_ERR;
        end else if (in_freq <= short_clamp_reg) begin
            item_next.mode = MODE_SHORT;
        end else begin
            item_next.mode = MODE_UNDEF;
        end

        unique case (item_next.mode)
            MODE_NORMAL, MODE_UNDERVOLT: begin
                item_next.undervoltage = (item_next.mode == MODE_UNDERVOLT);
                if (duty_open(in_duty, DUTY_NORM_LO, DUTY_NORM_HI)) begin
                    item_next.valid_res  = 1'b1;
                    item_next.meas_state = (item_next.mode == MODE_UNDERVOLT) ? ST_UV : ST_RES;
                    priority if (in_duty <= DUTY_DIV_MIN) begin
                        item_next.kind = RES_MAX;
                    end else if (in_duty > DUTY_RES_TOP) begin
                        item_next.kind = RES_ZERO;
                    end else begin
                        item_next.kind = RES_DIV;
                    end
                end else begin
                    item_next.meas_state =
                        (item_next.mode == MODE_UNDERVOLT) ? ST_UV_UNK : ST_RES_UNK;
                end
            end
            MODE_SPEEDSTART: begin
                priority if (duty_open(in_duty, DUTY_SSG_LO, DUTY_SSG_HI)) begin
                    item_next.valid_res  = 1'b1;
                    item_next.meas_state = ST_ESTIM;
                    item_next.kind       = RES_MAX;
                end else if (duty_open(in_duty, DUTY_SSB_LO, DUTY_SSB_HI)) begin
                    item_next.valid_res  = 1'b1;
                    item_next.meas_state = ST_ESTIM;
                end else begin
                    item_next.meas_state = ST_ESTIM_UNK;
                end
            end
            MODE_DEV_ERR, MODE_GND_ERR: begin
                if (duty_open(in_duty, DUTY_ERR_LO, DUTY_ERR_HI)) begin
                    item_next.valid_res  = 1'b1;
                    item_next.meas_state =
                        (item_next.mode == MODE_DEV_ERR) ? ST_DEVERR : ST_GNDERR;
                end else begin
                    item_next.meas_state =
                        (item_next.mode == MODE_DEV_ERR) ? ST_DEVERR_UNK : ST_GNDERR_UNK;
                end
            end
            MODE_SHORT: begin
                item_next.valid_res  = 1'b1;
                item_next.meas_state = ST_SHORT;
            end
            default: begin
                item_next.undervoltage = 1'b1;
                item_next.meas_state   = ST_INVALID;
            end
        endcase
    end

    // Output stage valid
    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Registers and configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            normal_c_reg    <= RST_NORMAL_CENTRE;
            uv_c_reg        <= RST_UV_CENTRE;
            ss_c_reg        <= RST_SS_CENTRE;
            deverr_c_reg    <= RST_DEVERR_CENTRE;
            gnderr_c_reg    <= RST_GNDERR_CENTRE;
            half_width_reg  <= RST_HALF_WIDTH;
            short_clamp_reg <= RST_SHORT_CLAMP;
        end else begin
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_NORMAL:      normal_c_reg    <= cfg_data;
                    CFG_UNDERVOLT:   uv_c_reg        <= cfg_data;
                    CFG_SPEEDSTART:  ss_c_reg        <= cfg_data;
                    CFG_DEV_ERR:     deverr_c_reg    <= cfg_data;
                    CFG_GND_ERR:     gnderr_c_reg    <= cfg_data;
                    CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[HW_W-1:0];
                    CFG_SHORT_CLAMP: short_clamp_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

[src/iwd_fifo.sv]
// Short word queue between the classifying front and the dividing back.
`timescale 1ns / 1ps

module iwd_fifo
    import iwd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[src/iwd_back.sv]
// Back: pipelined restoring divider for the resistance and the output register.
`timescale 1ns / 1ps

module iwd_back
    import iwd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    // stage k holds the partial remainder after k quotient bits
    logic             stg_vld_reg  [DIV_STAGES+1];
    item_t            stg_item_reg [DIV_STAGES+1];
    logic [DUTY_W-1:0] stg_rem_reg [DIV_STAGES+1];
    logic [RES_W-1:0] stg_quo_reg  [DIV_STAGES+1];
    logic [DUTY_W-1:0] stg_rem_next [DIV_STAGES+1];
    logic [RES_W-1:0] stg_quo_next [DIV_STAGES+1];
    logic             out_valid_reg;
    result_t          out_result_reg, out_result_next;
    logic             adv;

    // whole pipe moves when the output register can take a word
    assign adv        = !out_valid_reg || out_ready;
    assign in_ready   = adv;
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // One quotient bit per stage
    always_comb begin
        logic [DUTY_W:0] trial;
        logic            ge;
        stg_rem_next[0] = DIV_INIT;
        stg_quo_next[0] = '0;
        for (int k = 0; k < DIV_STAGES; k++) begin
            trial = {stg_rem_reg[k], DIV_DIVIDEND[DIV_STAGES-1-k]};
            ge    = (trial >= {1'b0, stg_item_reg[k].divisor});
            stg_rem_next[k+1] = ge ? DUTY_W'(trial - {1'b0, stg_item_reg[k].divisor})
                                   : trial[DUTY_W-1:0];
            stg_quo_next[k+1] = {stg_quo_reg[k][RES_W-2:0], ge};
        end
    end

    // Final resistance select
    always_comb begin
        out_result_next.mode           = stg_item_reg[DIV_STAGES].mode;
        out_result_next.meas_state     = stg_item_reg[DIV_STAGES].meas_state;
        out_result_next.valid_res      = stg_item_reg[DIV_STAGES].valid_res;
        out_result_next.undervoltage   = stg_item_reg[DIV_STAGES].undervoltage;
        out_result_next.status_pin_out = stg_item_reg[DIV_STAGES].status_pin;
        unique case (stg_item_reg[DIV_STAGES].kind)
            RES_MAX: out_result_next.insul_kohm = RES_MAX_KOHM;
            RES_DIV: out_result_next.insul_kohm = stg_quo_reg[DIV_STAGES] - RES_OFFSET;
            default: out_result_next.insul_kohm = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                stg_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            out_valid_reg  <= stg_vld_reg[DIV_STAGES];
            stg_vld_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                stg_vld_reg[k] <= stg_vld_reg[k-1];
            end
        end
        if (adv) begin
            out_result_reg  <= out_result_next;
            stg_item_reg[0] <= in_item;
            stg_rem_reg[0]  <= stg_rem_next[0];
            stg_quo_reg[0]  <= stg_quo_next[0];
            for (int k = 1; k <= DIV_STAGES; k++) begin
                stg_item_reg[k] <= stg_item_reg[k-1];
                stg_rem_reg[k]  <= stg_rem_next[k];
                stg_quo_reg[k]  <= stg_quo_next[k];
            end
        end
    end

endmodule

[src/insulation_pwm_status_decoder.sv]
// Top level of the insulation PWM status decoder: front, queue and back.
//
// Usage: one word on the s_ channel carries a measured PWM frequency
// (0.01 Hz), a duty cycle (0.01 %) and the status pin level. For each word
// one result word leaves on the m_ channel: mode, state code, validity,
// undervoltage flag, insulation resistance in kOhm and the pin level.
// The cfg_ channel writes the band centres, band half width and short
// clamp; it is always ready. The user must write it only while no word
// is in flight; the block does not enforce this. A word passes the
// classify register, queue, 17 divider stages of one quotient bit each
// and output register. Throughput: one word per cycle while m_tready
// is not held low; the divider pipeline retires one quotient per cycle.
// Reset (aresetn low, synchronous) empties the queue and pipeline and
// loads the default configuration.
// When the receiver holds m_tready low the output word holds, the divider
// pipeline freezes and the four-entry queue absorbs further words before
// s_tready falls.
`timescale 1ns / 1ps

module insulation_pwm_status_decoder
    import iwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] pwm_frequency, [29:16] pwm_duty, [30] status_pin, [31] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] mode, [6:3] meas_state, [7] valid_res, [8] undervoltage,
    // [25:9] insul_kohm, [26] status_pin_out, [31:27] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    fr_valid, fr_ready, bk_valid, bk_ready;
    item_t   fr_item, bk_item;
    result_t result;

    iwd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_freq   (s_tdata[15:0]),
        .in_duty   (s_tdata[29:16]),
        .in_pin    (s_tdata[30]),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    iwd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_item  (bk_item)
    );

    iwd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (bk_valid),
        .in_ready   (bk_ready),
        .in_item    (bk_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result word packing, first field lowest
    assign m_tdata = {5'b0, result.status_pin_out, result.insul_kohm,
                      result.undervoltage, result.valid_res,
                      result.meas_state, result.mode};

endmodule

[src/iwd_checker.sv]
// Port-level checks of the insulation PWM status decoder, bound to the top.
`timescale 1ns / 1ps

module iwd_checker
    import iwd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // output is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // resistance never exceeds its saturation value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[25:9] <= RES_MAX_KOHM)
        else $error("resistance above saturation");

    // an untrusted measurement carries no resistance
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[7] |-> m_tdata[25:9] == '0)
        else $error("resistance on invalid measurement");

    // error, short and undefined modes carry no resistance
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == MODE_DEV_ERR || m_tdata[2:0] == MODE_GND_ERR ||
                     m_tdata[2:0] == MODE_SHORT || m_tdata[2:0] == MODE_UNDEF)
        |-> m_tdata[25:9] == '0)
        else $error("resistance in error mode");

endmodule

bind insulation_pwm_status_decoder iwd_checker u_iwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
